@@ rtl/sspq_pkg.sv @@
// Shared types and constants of the stable sorted priority queue.
package sspq_pkg;

    localparam int CAPACITY      = 16;
    localparam int PAYLOAD_BITS  = 32;
    localparam int PRIORITY_BITS = 16;
    localparam int CNT_BITS      = $clog2(CAPACITY + 1);

    // Input beat layout: tdata holds priority_req, payload, priority_change.
    localparam int IN_DATA_BITS  = ((2 * PRIORITY_BITS + PAYLOAD_BITS + 7) / 8) * 8;
    // Output beat layout: tdata holds out_priority, out_payload, fill_count, is_empty.
    localparam int OUT_USED_BITS = PRIORITY_BITS + PAYLOAD_BITS + CNT_BITS + 1;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

    typedef logic signed [PRIORITY_BITS-1:0] t_prio;
    typedef logic        [PAYLOAD_BITS-1:0]  t_payload;
    typedef logic        [CNT_BITS-1:0]      t_count;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2,
        OP_CHANGE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic     en;
        t_op      op;
        t_prio    req_prio;
        t_payload req_payload;
        t_prio    change;
    } t_cmd;

    // One stored entry as handed between neighboring cells.
    typedef struct packed {
        t_prio    prio;
        t_payload payload;
    } t_entry;

endpackage

@@ rtl/sspq_cell.sv @@
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module sspq_cell
    import sspq_pkg::*;
(
    input  logic   i_clk,
    input  t_cmd   i_cmd,
    input  logic   i_occupied,
    input  logic   i_left_le,
    input  t_entry i_left,
    input  t_entry i_right,
    output logic   o_le,
    output t_entry o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    logic signed [PRIORITY_BITS:0] w_sum;
    t_prio                         w_sat;

    // This slot holds an entry that stays ahead of a new one of the request priority.
    assign o_le    = i_occupied && (r_entry.prio <= i_cmd.req_prio);
    assign o_entry = r_entry;

    // Saturating add of the change amount.
    always_comb begin
        w_sum = {r_entry.prio[PRIORITY_BITS-1], r_entry.prio}
              + {i_cmd.change[PRIORITY_BITS-1], i_cmd.change};
        if (w_sum[PRIORITY_BITS] != w_sum[PRIORITY_BITS-1]) begin
            w_sat = w_sum[PRIORITY_BITS]
                  ? t_prio'({1'b1, {(PRIORITY_BITS-1){1'b0}}})
                  : t_prio'({1'b0, {(PRIORITY_BITS-1){1'b1}}});
        end else begin
            w_sat = w_sum[PRIORITY_BITS-1:0];
        end
    end

    // Next contents: keep, take the new entry, shift right, shift left or adjust.
    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            OP_ENQUEUE: begin
                if (!o_le) begin
                    if (i_left_le) begin
                        n_entry.prio    = i_cmd.req_prio;
                        n_entry.payload = i_cmd.req_payload;
                    end else begin
                        n_entry = i_left;
                    end
                end
            end
            OP_DEQUEUE: begin
                n_entry = i_right;
            end
            OP_CHANGE: begin
                n_entry.prio = w_sat;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_entry <= n_entry;
        end
    end

endmodule

@@ rtl/stable_sorted_priority_queue.sv @@
// Top level of the stable sorted priority queue built as a chain of entry cells.
//
// Usage: one operation per input beat on the s_ channel. s_tuser carries the
// operation (0 enqueue, 1 dequeue, 2 peek, 3 change); s_tdata carries the
// request priority, the payload and the change amount. Every beat yields
// exactly one result beat on the m_ channel: m_tuser is the status (0 done,
// 1 empty, 2 full), m_tdata the head entry, the fill count and the empty flag.
// The result is registered and appears in the cycle after the input beat.
// Throughput is one operation per cycle unless m_tready stalls; every cell
// compares and shifts at once, so enqueue, dequeue and change all finish in
// the cycle they are taken. The result sits in one output register; while it
// waits, s_tready stays high if m_tready is high, and drops when the receiver
// stalls with a result held. Reset clears the fill count and the output valid
// and holds s_tready low; the entry cells hold no reset and are only read
// below the fill count. Equal priorities leave in arrival order.
module stable_sorted_priority_queue
    import sspq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [15:0] priority_req, [47:16] payload, [63:48] priority_change
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    // [1:0] kind
    input  logic [1:0]               s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [15:0] out_priority, [47:16] out_payload, [52:48] fill_count,
    // [53] is_empty, [55:54] zero
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    // [1:0] status
    output logic [1:0]               m_tuser
);

    t_count  r_count;
    t_count  n_count;
    logic    r_valid;
    t_status r_status;
    t_status n_status;
    t_entry  r_head;
    t_entry  n_head;

    logic    w_accept;
    logic    w_empty;
    logic    w_full;
    t_op     w_op;
    t_cmd    w_cmd;

    logic    w_le    [CAPACITY];
    t_entry  w_entry [CAPACITY];

    assign w_op     = t_op'(s_tuser);
    assign s_tready = i_rst_n && (!r_valid || m_tready);
    assign w_accept = s_tvalid && s_tready;
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == t_count'(CAPACITY));

    // Command to the chain; writes are suppressed when the store must not change.
    always_comb begin
        w_cmd.op          = w_op;
        w_cmd.req_prio    = t_prio'(s_tdata[PRIORITY_BITS-1:0]);
        w_cmd.req_payload = s_tdata[PRIORITY_BITS +: PAYLOAD_BITS];
        w_cmd.change      = t_prio'(s_tdata[PRIORITY_BITS + PAYLOAD_BITS +: PRIORITY_BITS]);
        w_cmd.en          = w_accept
                          && !((w_op == OP_ENQUEUE) && w_full)
                          && !((w_op == OP_DEQUEUE) && w_empty);
    end

    // Chain of cells, each linked to both neighbors.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   w_left_le;
        t_entry w_left;
        t_entry w_right;

        if (g == 0) begin : g_first
            assign w_left_le = 1'b1;
            assign w_left    = '{prio: w_cmd.req_prio, payload: w_cmd.req_payload};
        end else begin : g_mid
            assign w_left_le = w_le[g-1];
            assign w_left    = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        sspq_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_occupied (t_count'(g) < r_count),
            .i_left_le  (w_left_le),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_le       (w_le[g]),
            .o_entry    (w_entry[g])
        );
    end

    // Result of the accepted operation.
    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        n_head   = '0;
        case (w_op)
            OP_ENQUEUE: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + t_count'(1);
                end
            end
            OP_DEQUEUE, OP_PEEK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head = w_entry[0];
                    if (w_op == OP_DEQUEUE) begin
                        n_count = r_count - t_count'(1);
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Fill count and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_head   <= n_head;
        end
    end

    assign m_tvalid = r_valid;
    assign m_tuser  = r_status;
    assign m_tdata  = OUT_DATA_BITS'({(r_count == '0), r_count, r_head.payload, r_head.prio});

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench of the stable sorted priority queue.
module testbench;
    import sspq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT    = 2000;
    localparam int MAX_REPORTS    = 40;
    localparam int ITEMS_PER_LEG  = 567;

    // One operation as the sender presents it.
    typedef struct {
        t_op      kind;
        t_prio    prio;
        t_payload payload;
        t_prio    change;
        bit       wait_drain;
    } t_queue_cmd;

    // One reply as the queue should return it.
    typedef struct {
        t_status  status;
        t_prio    prio;
        t_payload payload;
        t_count   fill;
        logic     empty;
    } t_queue_reply;

    logic                     i_clk    = 1'b0;
    logic                     i_rst_n  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    // [15:0] priority_req, [47:16] payload, [63:48] priority_change
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
    // [1:0] kind
    logic [1:0]               s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // [15:0] out_priority, [47:16] out_payload, [52:48] fill_count, [53] is_empty
    logic [OUT_DATA_BITS-1:0] m_tdata;
    // [1:0] status
    logic [1:0]               m_tuser;

    // Operations waiting to be sent and replies still owed by the queue.
    t_queue_cmd   cmd_backlog[$];
    t_queue_reply predicted_replies[$];

    // Shadow copy of the sorted store.
    t_prio    shadow_prio[CAPACITY];
    t_payload shadow_payload[CAPACITY];
    int       shadow_count = 0;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  in_taken      = 1'b0;
    int  stall_cycles  = 0;
    int  gen_fill      = 0;
    bit  gen_filling   = 1'b1;

    int  error_count   = 0;
    int  op_count[4]   = '{0, 0, 0, 0};
    int  full_rejects  = 0;
    int  empty_reads   = 0;
    int  saturations   = 0;

    stable_sorted_priority_queue u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Apply one operation to the shadow store and return the reply it causes.
    function automatic t_queue_reply apply_queue_op(t_queue_cmd c);
        t_queue_reply r;
        int           pos;
        int           k;
        int           sum;
        bit           clamped;
        r.status  = ST_DONE;
        r.prio    = '0;
        r.payload = '0;
        clamped   = 1'b0;
        case (c.kind)
            OP_ENQUEUE: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // New entry goes behind every entry that is not greater.
                    pos = 0;
                    while (pos < shadow_count && shadow_prio[pos] <= c.prio)
                        pos++;
                    for (k = shadow_count; k > pos; k--) begin
                        shadow_prio[k]    = shadow_prio[k-1];
                        shadow_payload[k] = shadow_payload[k-1];
                    end
                    shadow_prio[pos]    = c.prio;
                    shadow_payload[pos] = c.payload;
                    shadow_count++;
                end
            end
            OP_DEQUEUE, OP_PEEK: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.prio    = shadow_prio[0];
                    r.payload = shadow_payload[0];
                    if (c.kind == OP_DEQUEUE) begin
                        for (k = 1; k < shadow_count; k++) begin
                            shadow_prio[k-1]    = shadow_prio[k];
                            shadow_payload[k-1] = shadow_payload[k];
                        end
                        shadow_count--;
                    end
                end
            end
            default: begin
                // Shift every priority, clamped to the signed range.
                for (k = 0; k < shadow_count; k++) begin
                    sum = int'(shadow_prio[k]) + int'(c.change);
                    if (sum > 32767) begin
                        sum = 32767;
                        clamped = 1'b1;
                    end else if (sum < -32768) begin
                        sum = -32768;
                        clamped = 1'b1;
                    end
                    shadow_prio[k] = t_prio'(sum);
                end
            end
        endcase
        if (clamped)
            saturations++;
        r.fill  = t_count'(shadow_count);
        r.empty = (shadow_count == 0);
        return r;
    endfunction

    // Report one field that differs from its prediction.
    function automatic void field_mismatch(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    // Queue one operation and track the fill level it leads to.
    function automatic void push_cmd(t_op kind, t_prio prio, t_payload payload, t_prio change,
                                     bit wait_drain);
        t_queue_cmd c;
        c.kind       = kind;
        c.prio       = prio;
        c.payload    = payload;
        c.change     = change;
        c.wait_drain = wait_drain;
        cmd_backlog.push_back(c);
        if (kind == OP_ENQUEUE && gen_fill < CAPACITY)
            gen_fill++;
        else if (kind == OP_DEQUEUE && gen_fill > 0)
            gen_fill--;
    endfunction

    // Driver: new beats and ready change at the falling edge.
    always @(negedge i_clk) begin : drive_proc
        t_queue_cmd c;
        bit         present;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (!s_tvalid || in_taken) begin
                present = 1'b0;
                if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    // A marked operation holds back until every reply is in.
                    if (!cmd_backlog[0].wait_drain || predicted_replies.size() == 0) begin
                        c = cmd_backlog.pop_front();
                        present = 1'b1;
                    end
                end
                s_tvalid <= present;
                if (present) begin
                    s_tdata <= {c.change, c.payload, c.prio};
                    s_tuser <= c.kind;
                end
            end
        end
    end

    // Monitor: check reply beats, then predict for the accepted input beat.
    always @(posedge i_clk) begin : monitor_proc
        t_queue_cmd   c;
        t_queue_reply want;
        in_taken = i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (predicted_replies.size() == 0) begin
                error_count++;
                $display("%0t: reply beat with none expected, got status %0d data 0x%0h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = predicted_replies.pop_front();
                field_mismatch("status", want.status, m_tuser);
                field_mismatch("out_priority", $unsigned(want.prio),
                               m_tdata[PRIORITY_BITS-1:0]);
                field_mismatch("out_payload", want.payload,
                               m_tdata[PRIORITY_BITS +: PAYLOAD_BITS]);
                field_mismatch("fill_count", want.fill,
                               m_tdata[PRIORITY_BITS+PAYLOAD_BITS +: CNT_BITS]);
                field_mismatch("is_empty", want.empty,
                               m_tdata[PRIORITY_BITS+PAYLOAD_BITS+CNT_BITS]);
            end
        end
        if (in_taken) begin
            c.kind       = t_op'(s_tuser);
            c.prio       = s_tdata[PRIORITY_BITS-1:0];
            c.payload    = s_tdata[PRIORITY_BITS +: PAYLOAD_BITS];
            c.change     = s_tdata[PRIORITY_BITS+PAYLOAD_BITS +: PRIORITY_BITS];
            c.wait_drain = 1'b0;
            want = apply_queue_op(c);
            predicted_replies.push_back(want);
            op_count[c.kind]++;
            if (want.status == ST_FULL)
                full_rejects++;
            else if (want.status == ST_EMPTY)
                empty_reads++;
        end
    end

    // Watchdog: ends the run when work is pending and no beat moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cmd_backlog.size() == 0 && predicted_replies.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Random leg with the given idle rates; returns once all replies are in.
    task automatic run_leg(int s_pct, int r_pct);
        int       n;
        int       r;
        t_op      kind;
        t_prio    prio;
        t_prio    change;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (n = 0; n < ITEMS_PER_LEG; n++) begin
            // Swing the fill level between empty and full.
            if (gen_fill == CAPACITY && $urandom_range(3) != 0)
                gen_filling = 1'b0;
            else if (gen_fill == 0 && $urandom_range(3) != 0)
                gen_filling = 1'b1;
            else if ($urandom_range(99) < 3)
                gen_filling = ~gen_filling;
            r = $urandom_range(99);
            if (gen_filling)
                kind = (r < 62) ? OP_ENQUEUE : (r < 77) ? OP_DEQUEUE :
                       (r < 89) ? OP_PEEK : OP_CHANGE;
            else
                kind = (r < 15) ? OP_ENQUEUE : (r < 70) ? OP_DEQUEUE :
                       (r < 85) ? OP_PEEK : OP_CHANGE;
            // Priorities: many close values for ties, some extremes, rest anywhere.
            r = $urandom_range(9);
            if (r < 4)
                prio = t_prio'(int'($urandom_range(8)) - 4);
            else if (r == 4)
                prio = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            else
                prio = t_prio'($urandom);
            r = $urandom_range(9);
            if (r < 6)
                change = t_prio'(int'($urandom_range(20)) - 10);
            else if (r == 6)
                change = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            else
                change = t_prio'($urandom);
            push_cmd(kind, prio, t_payload'($urandom), change,
                     n == 0 || $urandom_range(99) == 0);
        end
        while (cmd_backlog.size() > 0 || predicted_replies.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus_proc
        int k;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 60;
        // Reads and a change on the empty queue.
        push_cmd(OP_PEEK, '0, '0, '0, 1'b0);
        push_cmd(OP_DEQUEUE, '0, '0, '0, 1'b0);
        push_cmd(OP_CHANGE, '0, '0, 16'sh1234, 1'b0);
        // Extreme priorities and payloads, then two equal priorities in order.
        push_cmd(OP_ENQUEUE, 16'sh7fff, 32'h0000_0000, '0, 1'b0);
        push_cmd(OP_ENQUEUE, 16'sh8000, 32'hffff_ffff, '0, 1'b0);
        push_cmd(OP_ENQUEUE, 16'sh0000, 32'ha5a5_a5a5, '0, 1'b0);
        push_cmd(OP_ENQUEUE, 16'sh0000, 32'h5a5a_5a5a, '0, 1'b0);
        push_cmd(OP_PEEK, '0, '0, '0, 1'b0);
        // Saturate at the top, then at the bottom.
        push_cmd(OP_CHANGE, '0, '0, 16'sh7fff, 1'b0);
        push_cmd(OP_CHANGE, '0, '0, 16'sh8000, 1'b0);
        push_cmd(OP_DEQUEUE, '0, '0, '0, 1'b0);
        // Fill up with ties and then try once more on the full queue.
        for (k = 0; k < CAPACITY - 3; k++)
            push_cmd(OP_ENQUEUE, t_prio'((k % 3) - 1), t_payload'(k + 1), '0, 1'b0);
        push_cmd(OP_ENQUEUE, 16'sh0005, 32'hdead_beef, '0, 1'b0);

        run_leg(7, 60);
        run_leg(60, 7);
        run_leg(0, 0);

        // Let any stray reply beat show up.
        repeat (4) @(posedge i_clk);
        $display("Ran %0d operations: %0d enqueue, %0d dequeue, %0d peek, %0d change.",
                 op_count[OP_ENQUEUE] + op_count[OP_DEQUEUE] + op_count[OP_PEEK]
                 + op_count[OP_CHANGE], op_count[OP_ENQUEUE], op_count[OP_DEQUEUE],
                 op_count[OP_PEEK], op_count[OP_CHANGE]);
        $display("%0d full rejects, %0d empty reads, %0d saturating changes, %0d mismatches.",
                 full_rejects, empty_reads, saturations, error_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/sspq_pkg.sv
rtl/sspq_cell.sv
rtl/stable_sorted_priority_queue.sv
tb/testbench.sv
